### rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard pattern match package
// Shared types and constants for the glob matcher: the command codes carried
// by each transaction and the two wildcard byte values.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  // Default capacity of the pattern store, in bytes.
  localparam int DefaultMaxPattern = 64;

  // Wildcard bytes.
  localparam logic [7:0] StarByte  = 8'h2A;
  localparam logic [7:0] QmarkByte = 8'h3F;

  typedef enum logic [1:0] {
    ModeAppend     = 2'd0,
    ModeText       = 2'd1,
    ModeEndPattern = 2'd2,
    ModeEndText    = 2'd3
  } mode_e;

  // One command as it leaves the input register toward the datapath.
  typedef struct packed {
    logic       valid;
    mode_e      mode;
    logic [7:0] ch;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/wpm_pattern_store.sv
// ----------------------------------------------------------------------------
// Pattern store
// Holds the pattern bytes, the pattern length and the sticky overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_pattern_store #(
  parameter int MAX_PATTERN = wpm_pkg::DefaultMaxPattern
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire wpm_pkg::cmd_t                      cmd_i,
  output logic [MAX_PATTERN-1:0][7:0]             pat_o,
  output logic [MAX_PATTERN-1:0]                  used_o,
  output logic [$clog2(MAX_PATTERN+1)-1:0]        len_o,
  output logic                                    ovf_o
);
  import wpm_pkg::*;

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][7:0] pat_q;
  logic [LenW-1:0]             len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic                        append;
  logic                        full;

  assign append = cmd_i.valid && (cmd_i.mode == ModeAppend);
  assign full   = (len_q == LenW'(MAX_PATTERN));

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  // Each entry is written only at the current tail position.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (append && !full && (len_q == LenW'(i))) begin
        pat_q[i] <= cmd_i.ch;
      end
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_entry
    assign used_o[i] = (len_q > LenW'(i));
  end

  assign pat_o = pat_q;
  assign len_o = len_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

### rtl/wpm_reach.sv
// ----------------------------------------------------------------------------
// Reachability engine
// Keeps the vector of reachable pattern positions, applies star closure with
// a parallel prefix network and advances the vector by one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_reach #(
  parameter int MAX_PATTERN = wpm_pkg::DefaultMaxPattern
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire wpm_pkg::cmd_t                      cmd_i,
  input  wire logic [MAX_PATTERN-1:0][7:0]        pat_i,
  input  wire logic [MAX_PATTERN-1:0]             used_i,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]   len_i,
  output logic                                    match_o
);
  import wpm_pkg::*;

  localparam int NPos   = MAX_PATTERN + 1;
  localparam int Stages = $clog2(NPos);

  logic [NPos-1:0]        reach_q, reach_d, reach_next, closed;
  logic [MAX_PATTERN-1:0] star, adv;
  logic [NPos-1:0]        g_s [Stages+1];
  logic [NPos-1:0]        p_s [Stages+1];

  // Per-position classification of the stored pattern against this byte.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_class
    assign star[i] = used_i[i] && (pat_i[i] == StarByte);
    assign adv[i]  = used_i[i] && (pat_i[i] != StarByte) &&
                     ((pat_i[i] == QmarkByte) || (pat_i[i] == cmd_i.ch));
  end

  // Star closure is a carry chain: a reached position generates, and a star
  // before a position propagates. Kogge-Stone prefix over all positions.
  assign g_s[0]    = reach_q;
  assign p_s[0][0] = 1'b0;
  for (genvar j = 1; j < NPos; j++) begin : g_prop
    assign p_s[0][j] = star[j-1];
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int Dist = 1 << s;
    for (genvar j = 0; j < NPos; j++) begin : g_pos
      if (j >= Dist) begin : g_comb
        assign g_s[s+1][j] = g_s[s][j] | (p_s[s][j] & g_s[s][j-Dist]);
        assign p_s[s+1][j] = p_s[s][j] & p_s[s][j-Dist];
      end else begin : g_pass
        assign g_s[s+1][j] = g_s[s][j];
        assign p_s[s+1][j] = p_s[s][j];
      end
    end
  end

  assign closed = g_s[Stages];

  // A star stays reached; any other matching position moves one step on.
  for (genvar j = 0; j < NPos; j++) begin : g_next
    if (j == 0) begin : g_first
      assign reach_next[j] = closed[j] & star[j];
    end else if (j == MAX_PATTERN) begin : g_last
      assign reach_next[j] = closed[j-1] & adv[j-1];
    end else begin : g_mid
      assign reach_next[j] = (closed[j] & star[j]) | (closed[j-1] & adv[j-1]);
    end
  end

  always_comb begin
    reach_d = reach_q;
    if (cmd_i.valid) begin
      case (cmd_i.mode) inside
        ModeText:                    reach_d = reach_next;
        ModeEndPattern, ModeEndText: reach_d = NPos'(1);
        default:                     reach_d = reach_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= NPos'(1);
    end else begin
      reach_q <= reach_d;
    end
  end

  assign match_o = closed[len_i];

endmodule

`default_nettype wire

### rtl/wildcard_pattern_match.sv
// A transaction is registered at the input, processed from the input
// register, and an end-of-text result is held in the result register.
// Throughput: one transaction per cycle; the input stalls only while a
// finished result waits downstream and the next command is an end of text.
// Reset (asynchronous, active low) empties the pattern, clears the overflow
// flag and rearms the reachable set to position zero.
// ----------------------------------------------------------------------------
// Wildcard pattern match
// Streams a glob pattern ('?' one byte, '*' any run) into a store, then
// streams text bytes against it and reports a whole-text match per text.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_match #(
  parameter int MAX_PATTERN = wpm_pkg::DefaultMaxPattern
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] ch_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            matched_o,
  output logic            pattern_overflow_o
);
  import wpm_pkg::*;

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  // Input register: one accepted transaction waiting to be processed.
  logic       s1_valid_q, s1_valid_d;
  mode_e      s1_mode_q;
  logic [7:0] s1_ch_q;

  // Result register.
  logic out_valid_q, out_valid_d;
  logic matched_q, ovf_out_q;

  logic                        in_accept;
  logic                        advance;
  logic                        emit;
  cmd_t                        cmd;
  logic [MAX_PATTERN-1:0][7:0] pat;
  logic [MAX_PATTERN-1:0]      used;
  logic [LenW-1:0]             len;
  logic                        ovf;
  logic                        match;

  // The registered command moves on unless it would produce a result while
  // the result register is still held by the downstream side. Every other
  // command only updates state, so it never waits.
  assign advance    = s1_valid_q &&
                      !((s1_mode_q == ModeEndText) && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign emit       = advance && (s1_mode_q == ModeEndText);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q <= mode_e'(mode_i);
      s1_ch_q   <= ch_i;
    end
  end

  assign cmd.valid = advance;
  assign cmd.mode  = s1_mode_q;
  assign cmd.ch    = s1_ch_q;

  wpm_pattern_store #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .pat_o  (pat),
    .used_o (used),
    .len_o  (len),
    .ovf_o  (ovf)
  );

  wpm_reach #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_reach (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .pat_i   (pat),
    .used_i  (used),
    .len_i   (len),
    .match_o (match)
  );

  // The result register is freed by a downstream transaction and refilled by
  // an end-of-text command in the same cycle if one is ready.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      matched_q <= match;
      ovf_out_q <= ovf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

endmodule

`default_nettype wire

### rtl/wpm_checker.sv
// ----------------------------------------------------------------------------
// Wildcard pattern match checker
// Port-level assertions on the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] mode_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       matched_o,
  input wire logic       pattern_overflow_o
);
  import wpm_pkg::*;

  logic seen_ovf_q;
  logic end_text;

  assign end_text = (mode_i == ModeEndText);

  // Overflow is cleared only by reset, so once reported it stays reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ovf_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && pattern_overflow_o) begin
      seen_ovf_q <= 1'b1;
    end
  end

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction withdrawn while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A fresh result comes from an end-of-text transaction that was taken into
  // the input register and from there into the result register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && end_text, 2))
    else $error("result appeared without an end-of-text transaction");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_ovf_q |-> pattern_overflow_o)
    else $error("overflow flag dropped without reset");

  logic unused_matched;
  assign unused_matched = matched_o;

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (.*);

`default_nettype wire

### tb/sv/tb_wildcard_pattern_match.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard pattern match testbench
// Self-checking bench for the glob matcher. A short table of directed
// transactions covers the empty pattern, both wildcards, byte extremes,
// appends after text has begun and a mid-text end of pattern. Random rounds
// then grow the stored pattern until it overflows while streaming mostly
// matching texts against it. Every end-of-text verdict is checked against
// an in-bench model of the reachable-position vector or a hand-written answer.
// ----------------------------------------------------------------------------

module tb_wildcard_pattern_match;

  import wpm_pkg::*;

  localparam int PatCap     = DefaultMaxPattern;
  localparam int RandItems  = 1750;
  localparam int DrainCycles = 16;

  // One end-of-text verdict as the block should report it.
  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // One row of the directed table. When typed is set, the verdict fields
  // hold the answer written out by hand instead of the predicted one.
  typedef struct packed {
    mode_e      mode;
    logic [7:0] ch;
    logic       typed;
    logic       t_match;
    logic       t_ovf;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals toward the block. Every input starts known.
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [1:0] mode      = ModeAppend;
  logic [7:0] ch        = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       matched;
  logic       pattern_overflow;

  always #1 clk = ~clk;

  wildcard_pattern_match #(
    .MAX_PATTERN(PatCap)
  ) u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (mode),
    .ch_i              (ch),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .matched_o         (matched),
    .pattern_overflow_o(pattern_overflow)
  );

  // --------------------------------------------------------------------------
  // Matcher mirror. The glob is kept as the block keeps it: a store that only
  // grows, a length, the overflow flag and the set of reachable positions,
  // held without star closure.
  // --------------------------------------------------------------------------
  logic [7:0]    glob_mem [PatCap];
  logic [6:0]    glob_len      = '0;
  logic          glob_overflow = 1'b0;
  logic [PatCap:0] reach_set   = (PatCap + 1)'(1);

  verdict_t      pending_verdicts [$];
  logic [7:0]    text_q [$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int            items_sent    = 0;
  int            err_count     = 0;

  // A position that is reachable and sits in front of a star also makes the
  // position after the star reachable, since the star may match nothing.
  function automatic logic [PatCap:0] star_closure();
    logic [PatCap:0] closed;
    closed = reach_set;
    for (int k = 0; k < int'(glob_len); k++) begin
      closed[k+1] = reach_set[k+1] | (closed[k] & (glob_mem[k] == StarByte));
    end
    return closed;
  endfunction

  // Applies one accepted transaction to the mirror and reports the verdict
  // that an end of text produces.
  task automatic advance_matcher(input mode_e m, input logic [7:0] c,
                                 output bit has_verdict, output verdict_t v);
    logic [PatCap:0] closed;
    has_verdict = 1'b0;
    v = '0;
    case (m)
      ModeAppend: begin
        // A full store drops the byte and raises the sticky flag.
        if (int'(glob_len) < PatCap) begin
          glob_mem[glob_len] = c;
          glob_len = glob_len + 1'b1;
        end else begin
          glob_overflow = 1'b1;
        end
      end
      ModeText: begin
        closed = star_closure();
        reach_set = '0;
        for (int k = 0; k < int'(glob_len); k++) begin
          if (closed[k]) begin
            if (glob_mem[k] == StarByte) begin
              reach_set[k] = 1'b1;
            end else if (glob_mem[k] == QmarkByte || glob_mem[k] == c) begin
              reach_set[k+1] = 1'b1;
            end
          end
        end
      end
      ModeEndPattern: begin
        reach_set = (PatCap + 1)'(1);
      end
      default: begin
        closed = star_closure();
        has_verdict = 1'b1;
        v.matched = closed[glob_len];
        v.overflow = glob_overflow;
        reach_set = (PatCap + 1)'(1);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender. Idle cycles are inserted before the transaction; valid is only
  // lowered while idling, so a back-to-back transaction keeps valid high.
  // The payload is held until the block takes it.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input mode_e m, input logic [7:0] c, input bit typed,
                          input bit t_match, input bit t_ovf);
    bit       has_verdict;
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_matcher(m, c, has_verdict, v);
    if (has_verdict) begin
      if (typed) begin
        v.matched  = t_match;
        v.overflow = t_ovf;
      end
      pending_verdicts.insert(pending_verdicts.size(), v);
    end
    items_sent++;
  endtask

  // Holds the sender off until every verdict in flight has come back.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Text bytes under wildcards come mostly from the same small alphabet as
  // the literals, so that stars have real choices to make.
  function automatic logic [7:0] random_text_byte();
    if ($urandom_range(0, 1)) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  // Streams one text. It is built to follow the current glob and is then,
  // now and then, broken by changing, dropping or inserting one byte. Rare
  // stray transactions of any kind are mixed into the stream.
  task automatic send_text();
    int idx;
    text_q.delete();
    for (int k = 0; k < int'(glob_len); k++) begin
      if (glob_mem[k] == StarByte) begin
        repeat ($urandom_range(0, 2)) text_q.insert(text_q.size(), random_text_byte());
      end else if (glob_mem[k] == QmarkByte) begin
        text_q.insert(text_q.size(), random_text_byte());
      end else begin
        text_q.insert(text_q.size(), glob_mem[k]);
      end
    end
    if ($urandom_range(0, 99) < 30) begin
      idx = $urandom_range(0, text_q.size());
      case ($urandom_range(0, 2))
        0: if (idx < text_q.size()) text_q[idx] = random_text_byte();
        1: if (idx < text_q.size()) text_q.delete(idx);
        default: text_q.insert(idx, random_text_byte());
      endcase
    end
    foreach (text_q[k]) begin
      if ($urandom_range(0, 99) < 3) begin
        send_cmd(mode_e'($urandom_range(0, 3)), 8'($urandom), 1'b0, 1'b0, 1'b0);
      end
      send_cmd(ModeText, text_q[k], 1'b0, 1'b0, 1'b0);
    end
    send_cmd(ModeEndText, 8'($urandom), 1'b0, 1'b0, 1'b0);
  endtask

  // One random round: grow the glob by a few bytes, sometimes close it, and
  // run one or two texts against it. Once the store is full the appends
  // land on the overflow path.
  task automatic run_round();
    logic [7:0] gb;
    repeat ($urandom_range(2, 4)) begin
      case ($urandom_range(0, 9))
        0, 1:    gb = StarByte;
        2, 3:    gb = QmarkByte;
        9:       gb = 8'($urandom);
        default: gb = 8'h61 + 8'($urandom_range(0, 2));
      endcase
      send_cmd(ModeAppend, gb, 1'b0, 1'b0, 1'b0);
    end
    if ($urandom_range(0, 1)) send_cmd(ModeEndPattern, 8'($urandom), 1'b0, 1'b0, 1'b0);
    repeat ($urandom_range(1, 2)) send_text();
  endtask

  // --------------------------------------------------------------------------
  // Receiver. A verdict is taken at an edge with valid high and stall low,
  // and compared with the oldest expectation. Stall is redrawn every cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected verdict: matched %0b overflow %0b", matched,
                 pattern_overflow);
          err_count++;
        end else begin
          v = pending_verdicts.pop_front();
          if (matched !== v.matched) begin
            $error("matched: expected %0b, actual %0b", v.matched, matched);
            err_count++;
          end
          if (pattern_overflow !== v.overflow) begin
            $error("pattern_overflow: expected %0b, actual %0b", v.overflow,
                   pattern_overflow);
            err_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed verdict are the ones that can be read
  // off directly: the empty glob with and without text, and a mid-text end
  // of pattern, which leaves only position zero in front of a literal.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [25] = '{
    // Empty glob: the empty text matches, any text does not.
    '{ModeEndText,    8'h00, 1'b1, 1'b1, 1'b0},
    '{ModeText,       8'h78, 1'b0, 1'b0, 1'b0},
    '{ModeEndText,    8'hFF, 1'b1, 1'b0, 1'b0},
    '{ModeEndPattern, 8'h55, 1'b0, 1'b0, 1'b0},
    '{ModeEndText,    8'hAA, 1'b1, 1'b1, 1'b0},
    // Build "a*?" and close it, then match "abc" through the star.
    '{ModeAppend,     8'h61, 1'b0, 1'b0, 1'b0},
    '{ModeAppend,     8'h2A, 1'b0, 1'b0, 1'b0},
    '{ModeAppend,     8'h3F, 1'b0, 1'b0, 1'b0},
    '{ModeEndPattern, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'h61, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'h62, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'h63, 1'b0, 1'b0, 1'b0},
    '{ModeEndText,    8'h00, 1'b0, 1'b0, 1'b0},
    // Byte extremes as literal and as text, star matching nothing.
    '{ModeAppend,     8'hFF, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'h61, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'h00, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'hFF, 1'b0, 1'b0, 1'b0},
    '{ModeEndText,    8'h3F, 1'b0, 1'b0, 1'b0},
    // Append after the text has begun: the new position starts clear.
    '{ModeText,       8'h61, 1'b0, 1'b0, 1'b0},
    '{ModeAppend,     8'h00, 1'b0, 1'b0, 1'b0},
    '{ModeText,       8'h7E, 1'b0, 1'b0, 1'b0},
    '{ModeEndText,    8'h2A, 1'b0, 1'b0, 1'b0},
    // End of pattern mid-text rearms to position zero only.
    '{ModeText,       8'h61, 1'b0, 1'b0, 1'b0},
    '{ModeEndPattern, 8'h2A, 1'b0, 1'b0, 1'b0},
    '{ModeEndText,    8'h00, 1'b1, 1'b0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Main sequence. Reset once, run the table, then three random phases:
  // often idle receiver, often idle sender, and no idling at all. Between
  // phases the sender waits for every verdict. The last phase keeps going
  // until the store has overflowed, so the full-store path is always hit.
  // --------------------------------------------------------------------------
  initial begin
    int phase_end;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 49;
    foreach (directed_rows[r]) begin
      send_cmd(directed_rows[r].mode, directed_rows[r].ch, directed_rows[r].typed,
               directed_rows[r].t_match, directed_rows[r].t_ovf);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = (ph + 1) * RandItems / 3;
      while (items_sent < phase_end || (ph == 2 && !glob_overflow)) run_round();
      wait_for_verdicts();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
